>>> hw/rtl/isq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isq_pkg
// Types and codes shared by the indexed sequence store and its cell chain.
// ----------------------------------------------------------------------------
package isq_pkg;

    // Widest cell index supported (capacity up to 4096)
    localparam int IDX_W_MAX = 12;

    localparam int OP_W     = 4;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int ECOUNT_W = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_TAIL  = 4'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd1;
    localparam logic [OP_W-1:0] OP_INSERT     = 4'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd3;
    localparam logic [OP_W-1:0] OP_POP_HEAD   = 4'd4;
    localparam logic [OP_W-1:0] OP_REMOVE_AT  = 4'd5;
    localparam logic [OP_W-1:0] OP_READ       = 4'd6;
    localparam logic [OP_W-1:0] OP_WRITE      = 4'd7;
    localparam logic [OP_W-1:0] OP_FRONT      = 4'd8;
    localparam logic [OP_W-1:0] OP_BACK       = 4'd9;
    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd10;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    // Cell update modes
    localparam logic [1:0] CM_HOLD  = 2'd0;
    localparam logic [1:0] CM_OPEN  = 2'd1; // take left neighbour above the gap
    localparam logic [1:0] CM_CLOSE = 2'd2; // take right neighbour from the gap up
    localparam logic [1:0] CM_WRITE = 2'd3;

    typedef logic [IDX_W_MAX-1:0] t_idx;

    typedef struct packed {
        logic [1:0] mode;
        t_idx       at;     // target index of open, close or write
        t_idx       rd_at;  // index driven onto the read bus
    } t_cell_ctrl;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] item_value;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [VAL_W-1:0]    read_value;
        logic [ECOUNT_W-1:0] element_count;
    } t_out;

endpackage

>>> hw/rtl/isq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isq_cell
// One storage cell: holds one element, shifts with its neighbours.
// ----------------------------------------------------------------------------
module isq_cell
    import isq_pkg::*;
#(
    parameter int DW       = 32,
    parameter int CELL_IDX = 0
) (
    input  logic          i_clk,
    input  t_cell_ctrl    i_ctrl,
    input  logic [DW-1:0] i_value,
    input  logic [DW-1:0] i_left,
    input  logic [DW-1:0] i_right,
    output logic [DW-1:0] o_data,
    output logic [DW-1:0] o_rd
);

    localparam t_idx MY_IDX = t_idx'(CELL_IDX);

    logic [DW-1:0] r_data;
    logic [DW-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctrl.mode)
            CM_OPEN: begin
                if (MY_IDX == i_ctrl.at) begin
                    n_data = i_value;
                end else if (MY_IDX > i_ctrl.at) begin
                    n_data = i_left;
                end
            end
            CM_CLOSE: begin
                if (MY_IDX >= i_ctrl.at) begin
                    n_data = i_right;
                end
            end
            CM_WRITE: begin
                if (MY_IDX == i_ctrl.at) begin
                    n_data = i_value;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_rd   = (MY_IDX == i_ctrl.rd_at) ? r_data : '0;

endmodule

>>> hw/rtl/isq_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isq_chain
// Row of storage cells with neighbour links and a shared read bus.
// ----------------------------------------------------------------------------
module isq_chain
    import isq_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int DW       = 32
) (
    input  logic          i_clk,
    input  t_cell_ctrl    i_ctrl,
    input  logic [DW-1:0] i_value,
    output logic [DW-1:0] o_rd
);

    logic [DW-1:0] w_data [CAPACITY];
    logic [DW-1:0] w_rd   [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cells
        logic [DW-1:0] w_left;
        logic [DW-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        isq_cell #(
            .DW       (DW),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (i_ctrl),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_rd    (w_rd[g])
        );
    end

    // only the addressed cell drives non-zero
    always_comb begin
        o_rd = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            o_rd = o_rd | w_rd[k];
        end
    end

endmodule

>>> hw/rtl/indexed_sequence_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Ordered sequence of up to CAPACITY values held in a chain of cells.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------
//  in      | to block  | i_in_valid / o_in_ready  | i_in  (operation, position,
//          |           |                          |        item_value)
//  out     | from block| o_out_valid / i_out_ready| o_out (status, read_value,
//          |           |                          |        element_count)
//
// On an operation each cell takes its left or right
// neighbour, the new value, or holds, so inserts and removes shift the whole
// row at once. One transaction per cycle while the output side keeps up.
// The result sits in an output register; a new transaction is taken whenever
// that register is empty or being drained in the same cycle.
// Reset (i_rst_n low, synchronous) empties the sequence and the output
// register. Cell contents are not reset; only entries below the count are
// ever read.
// ----------------------------------------------------------------------------
module indexed_sequence_store
    import isq_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,

    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,

    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out          r_out;
    t_out          n_out;

    logic                  w_acc;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_in_rng;
    logic [IW-1:0]         w_pos;
    logic [IW-1:0]         w_last;
    logic                  w_rd_en;
    logic [STAT_W-1:0]     w_status;
    t_cell_ctrl            w_ctrl;
    logic [DATA_WIDTH-1:0] w_value;
    logic [DATA_WIDTH-1:0] w_rd;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_acc      = i_in_valid && o_in_ready;

    assign w_full   = (r_count == FULL_COUNT);
    assign w_empty  = (r_count == '0);
    assign w_in_rng = (CMPW'(i_in.position) < CMPW'(r_count));
    // position and count-1 are only used where they fall below CAPACITY
    assign w_pos    = IW'(i_in.position);
    assign w_last   = IW'(r_count - 1'b1);
    assign w_value  = DATA_WIDTH'(i_in.item_value);

    // ------------------------------------------------------------------
    // Operation decode: cell commands, next count, status
    // ------------------------------------------------------------------
    always_comb begin
        w_ctrl.mode  = CM_HOLD;
        w_ctrl.at    = '0;
        w_ctrl.rd_at = '0;
        w_rd_en      = 1'b0;
        w_status     = ST_OK;
        n_count      = r_count;

        case (i_in.operation)
            OP_PUSH_TAIL, OP_PUSH_FRONT, OP_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.mode = CM_OPEN;
                    n_count     = r_count + 1'b1;
                    if (i_in.operation == OP_PUSH_FRONT) begin
                        w_ctrl.at = '0;
                    end else if (i_in.operation == OP_INSERT && w_in_rng) begin
                        w_ctrl.at = t_idx'(w_pos);
                    end else begin
                        // append: count is below CAPACITY here
                        w_ctrl.at = t_idx'(IW'(r_count));
                    end
                end
            end
            OP_POP_BACK: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_POP_HEAD: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctrl.mode = CM_CLOSE;
                    w_ctrl.at   = '0;
                    n_count     = r_count - 1'b1;
                end
            end
            OP_REMOVE_AT: begin
                if (!w_in_rng) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.mode = CM_CLOSE;
                    w_ctrl.at   = t_idx'(w_pos);
                    n_count     = r_count - 1'b1;
                end
            end
            OP_READ: begin
                if (!w_in_rng) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.rd_at = t_idx'(w_pos);
                    w_rd_en      = 1'b1;
                end
            end
            OP_WRITE: begin
                if (!w_in_rng) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctrl.mode = CM_WRITE;
                    w_ctrl.at   = t_idx'(w_pos);
                end
            end
            OP_FRONT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctrl.rd_at = '0;
                    w_rd_en      = 1'b1;
                end
            end
            OP_BACK: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctrl.rd_at = t_idx'(w_last);
                    w_rd_en      = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // unused codes: no change, status ok
                n_count = r_count;
            end
        endcase

        // cells only move on an accepted transaction
        if (!w_acc) begin
            w_ctrl.mode = CM_HOLD;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    isq_chain #(
        .CAPACITY (CAPACITY),
        .DW       (DATA_WIDTH)
    ) u_chain (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_value (w_value),
        .o_rd    (w_rd)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb begin
        n_out.status        = w_status;
        n_out.read_value    = w_rd_en ? VAL_W'(w_rd) : '0;
        n_out.element_count = ECOUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("element count above capacity");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("transaction taken while result stalled");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(r_count))
        else $error("count moved without a transaction");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_status == ST_FULL) |-> (r_count == FULL_COUNT && n_count == r_count))
        else $error("full reported below capacity");

endmodule
